/* rtl/cbs_pkg.sv */
package cbs_pkg;

  localparam int MAX_SEGMENTS = 63;
  localparam int SEG_W = 6;
  localparam int STEP_W = 17;

  // Effective segment limit, never more than the sample index can count.
  localparam logic [SEG_W-1:0] SEG_LIMIT = SEG_W'((MAX_SEGMENTS > 63) ? 63 : MAX_SEGMENTS);
  localparam logic [SEG_W-1:0] SEG_MIN = SEG_W'(1);

  // Parameter value of exactly one in Q1.16.
  localparam logic [STEP_W-1:0] T_ONE = STEP_W'(65536);

  // Points in the sliding window.
  localparam logic [2:0] WIN_PTS = 3'd4;

  // Register stages inside one coordinate lane.
  localparam int LANE_STAGES = 9;

  typedef enum logic {
    ACT_PUSH  = 1'b0,
    ACT_CLEAR = 1'b1
  } cbs_action_t;

  typedef enum logic {
    CFG_SEGMENT_COUNT = 1'b0,
    CFG_STEP_FRACTION = 1'b1
  } cbs_cfg_idx_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cbs_qstat_t;

  typedef struct packed {
    logic             valid;
    logic [SEG_W-1:0] index;
    logic             last;
  } cbs_meta_t;

endpackage

/* rtl/cbs_queue.sv */
module cbs_queue #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                pop,
  output logic [WIDTH-1:0]    head,
  output cbs_pkg::cbs_qstat_t qstat
);
  import cbs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign head = mem_r[rd_ptr_r];
  assign qstat.full = (cnt_r == FULL_CNT);
  assign qstat.empty = (cnt_r == '0);

endmodule

/* rtl/cbs_front.sv */
module cbs_front #(
  parameter int CW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic signed [CW-1:0] in_ctrl_x,
  input  logic signed [CW-1:0] in_ctrl_y,
  input  cbs_pkg::cbs_qstat_t qstat,
  output logic                q_push,
  output logic [8*CW-1:0]     q_wdata
);
  import cbs_pkg::*;

  logic [3:0][CW-1:0] win_x_r, win_x_nxt;
  logic [3:0][CW-1:0] win_y_r, win_y_nxt;
  logic [2:0]         held_r, held_nxt;
  logic               fire;
  logic               is_clear;

  assign in_ready = !qstat.full;
  assign fire = in_valid && in_ready;
  assign is_clear = (cbs_action_t'(in_action) == ACT_CLEAR);

  always_comb begin
    win_x_nxt = win_x_r;
    win_y_nxt = win_y_r;
    held_nxt = held_r;
    q_push = 1'b0;
    if (fire) begin
      if (is_clear) begin
        win_x_nxt = '0;
        win_y_nxt = '0;
        held_nxt = '0;
      end else begin
        // Element 0 holds the oldest point.
        win_x_nxt = {in_ctrl_x, win_x_r[3:1]};
        win_y_nxt = {in_ctrl_y, win_y_r[3:1]};
        held_nxt = (held_r == WIN_PTS) ? WIN_PTS : held_r + 3'd1;
        q_push = (held_nxt == WIN_PTS);
      end
    end
  end

  assign q_wdata = {win_x_nxt, win_y_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_x_r <= win_x_nxt;
    win_y_r <= win_y_nxt;
  end

endmodule

/* rtl/cbs_lane.sv */
module cbs_lane #(
  parameter int CW = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [3:0][CW-1:0] pts,
  input  logic [15:0]        tlo,
  input  logic               tfull,
  output logic [CW+7:0]      res
);

  localparam int CF = CW + 4;
  localparam int W1 = CW + 21;
  localparam int W2 = CW + 38;
  localparam int W3 = CW + 55;
  localparam int RW = CW + 8;
  localparam int DW = CW + 11;
  localparam int SP1 = W1 / 2;
  localparam int SP2 = W2 / 2;

  // Rounding half plus an offset of three times 2^RW, so the quotient by three
  // stays nonnegative and its low RW bits are the signed result.
  localparam logic signed [W3-1:0] RND = (W3'(3) <<< 40) + (W3'(3) <<< (RW + 41));
  localparam logic [DW+2:0] RECIP_NUM = ((DW+3)'(1) << (DW + 2)) + (DW+3)'(2);
  localparam logic [DW:0] RECIP = (DW+1)'(RECIP_NUM / (DW+3)'(3));

  logic signed [CF-1:0] p0, p1, p2, p3;
  logic signed [CF-1:0] a0, a1, a2, a3;

  logic signed [CF-1:0] a0_0_r, a1_0_r, a2_0_r, a3_0_r;
  logic [15:0]          tlo_0_r;
  logic                 tf_0_r;

  logic signed [W1-1:0] m1_1_r;
  logic signed [CF-1:0] a0_1_r, a1_1_r, a2_1_r, a3_1_r;
  logic [15:0]          tlo_1_r;
  logic                 tf_1_r;

  logic signed [W1-1:0] h1_nxt;
  logic signed [W1-1:0] h1_2_r;
  logic signed [CF-1:0] a0_2_r, a1_2_r;
  logic [15:0]          tlo_2_r;
  logic                 tf_2_r;

  logic [SP1+15:0]             pl_3_r;
  logic signed [W1-SP1+16:0]   ph_3_r;
  logic signed [W1-1:0]        h1_3_r;
  logic signed [CF-1:0]        a0_3_r, a1_3_r;
  logic [15:0]                 tlo_3_r;
  logic                        tf_3_r;

  logic signed [W2-1:0] h2_nxt;
  logic signed [W2-1:0] h2_4_r;
  logic signed [CF-1:0] a0_4_r;
  logic [15:0]          tlo_4_r;
  logic                 tf_4_r;

  logic [SP2+15:0]           pl_5_r;
  logic signed [W2-SP2+16:0] ph_5_r;
  logic signed [W2-1:0]      h2_5_r;
  logic signed [CF-1:0]      a0_5_r;
  logic                      tf_5_r;

  logic signed [W3-1:0] h3_nxt;
  logic signed [W3-1:0] h3_6_r;
  logic signed [W3-1:0] sum7;
  logic [DW-1:0]        d_7_r;
  logic [2*DW:0]        prod_8_r;

  // Power-basis coefficients of six times the uniform B-spline segment.
  always_comb begin
    p0 = CF'($signed(pts[0]));
    p1 = CF'($signed(pts[1]));
    p2 = CF'($signed(pts[2]));
    p3 = CF'($signed(pts[3]));
    a3 = (p3 - p0) + ((p1 - p2) <<< 1) + (p1 - p2);
    a2 = ((p0 + p2) <<< 1) + (p0 + p2) - (p1 <<< 2) - (p1 <<< 1);
    a1 = ((p2 - p0) <<< 1) + (p2 - p0);
    a0 = p0 + (p1 <<< 2) + p2;
  end

  // Horner steps; a parameter of exactly one enters as a shift by 16.
  always_comb begin
    h1_nxt = m1_1_r + (W1'(a2_1_r) <<< 16);
    if (tf_1_r) begin
      h1_nxt = h1_nxt + (W1'(a3_1_r) <<< 16);
    end
    h2_nxt = (W2'(ph_3_r) <<< SP1) + W2'($signed({1'b0, pl_3_r})) + (W2'(a1_3_r) <<< 32);
    if (tf_3_r) begin
      h2_nxt = h2_nxt + (W2'(h1_3_r) <<< 16);
    end
    h3_nxt = (W3'(ph_5_r) <<< SP2) + W3'($signed({1'b0, pl_5_r})) + (W3'(a0_5_r) <<< 48);
    if (tf_5_r) begin
      h3_nxt = h3_nxt + (W3'(h2_5_r) <<< 16);
    end
    sum7 = h3_6_r + RND;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_0_r <= a0;
      a1_0_r <= a1;
      a2_0_r <= a2;
      a3_0_r <= a3;
      tlo_0_r <= tlo;
      tf_0_r <= tfull;

      m1_1_r <= a3_0_r * $signed({1'b0, tlo_0_r});
      a0_1_r <= a0_0_r;
      a1_1_r <= a1_0_r;
      a2_1_r <= a2_0_r;
      a3_1_r <= a3_0_r;
      tlo_1_r <= tlo_0_r;
      tf_1_r <= tf_0_r;

      h1_2_r <= h1_nxt;
      a0_2_r <= a0_1_r;
      a1_2_r <= a1_1_r;
      tlo_2_r <= tlo_1_r;
      tf_2_r <= tf_1_r;

      pl_3_r <= h1_2_r[SP1-1:0] * tlo_2_r;
      ph_3_r <= $signed(h1_2_r[W1-1:SP1]) * $signed({1'b0, tlo_2_r});
      h1_3_r <= h1_2_r;
      a0_3_r <= a0_2_r;
      a1_3_r <= a1_2_r;
      tlo_3_r <= tlo_2_r;
      tf_3_r <= tf_2_r;

      h2_4_r <= h2_nxt;
      a0_4_r <= a0_3_r;
      tlo_4_r <= tlo_3_r;
      tf_4_r <= tf_3_r;

      pl_5_r <= h2_4_r[SP2-1:0] * tlo_4_r;
      ph_5_r <= $signed(h2_4_r[W2-1:SP2]) * $signed({1'b0, tlo_4_r});
      h2_5_r <= h2_4_r;
      a0_5_r <= a0_4_r;
      tf_5_r <= tf_4_r;

      h3_6_r <= h3_nxt;

      d_7_r <= sum7[41 +: DW];

      prod_8_r <= d_7_r * RECIP;
    end
  end

  assign res = prod_8_r[DW+2 +: RW];

endmodule

/* rtl/cbs_back.sv */
module cbs_back #(
  parameter int CW = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cbs_pkg::SEG_W-1:0]   seg_count,
  input  logic [cbs_pkg::STEP_W-1:0]  step,
  input  logic [8*CW-1:0]             q_head,
  input  cbs_pkg::cbs_qstat_t         qstat,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [CW+7:0]        out_curve_x,
  output logic signed [CW+7:0]        out_curve_y,
  output logic [cbs_pkg::SEG_W-1:0]   out_sample_index,
  output logic                        out_last
);
  import cbs_pkg::*;

  logic               en;
  logic               issue;
  logic [SEG_W-1:0]   n_eff;
  logic               last;
  logic               tfull;
  logic [15:0]        tlo;
  logic [STEP_W:0]    t_sum;
  logic [SEG_W-1:0]   k_r, k_nxt;
  logic [STEP_W-1:0]  t_r, t_nxt;
  logic [3:0][CW-1:0] pts_x, pts_y;
  logic [CW+7:0]      res_x, res_y;
  cbs_meta_t          meta_r [LANE_STAGES];
  cbs_meta_t          meta_tail;

  logic                 out_valid_r;
  logic signed [CW+7:0] out_x_r, out_y_r;
  logic [SEG_W-1:0]     out_idx_r;
  logic                 out_last_r;

  // The whole pipeline moves whenever the output register can take a result.
  assign en = !out_valid_r || out_ready;
  assign issue = en && !qstat.empty;

  always_comb begin
    if (seg_count < SEG_MIN) begin
      n_eff = SEG_MIN;
    end else if (seg_count > SEG_LIMIT) begin
      n_eff = SEG_LIMIT;
    end else begin
      n_eff = seg_count;
    end
  end

  assign last = (k_r == n_eff);
  assign tfull = last || (t_r == T_ONE);
  assign tlo = tfull ? 16'h0000 : t_r[15:0];
  assign t_sum = {1'b0, t_r} + {1'b0, step};
  assign q_pop = issue && last;

  always_comb begin
    k_nxt = k_r;
    t_nxt = t_r;
    if (issue) begin
      if (last) begin
        k_nxt = '0;
        t_nxt = '0;
      end else begin
        k_nxt = k_r + SEG_W'(1);
        t_nxt = (t_sum > {1'b0, T_ONE}) ? T_ONE : t_sum[STEP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      t_r <= '0;
    end else begin
      k_r <= k_nxt;
      t_r <= t_nxt;
    end
  end

  assign pts_x = q_head[8*CW-1:4*CW];
  assign pts_y = q_head[4*CW-1:0];

  cbs_lane #(.CW(CW)) u_lane_x (
    .clk   (clk),
    .en    (en),
    .pts   (pts_x),
    .tlo   (tlo),
    .tfull (tfull),
    .res   (res_x)
  );

  cbs_lane #(.CW(CW)) u_lane_y (
    .clk   (clk),
    .en    (en),
    .pts   (pts_y),
    .tlo   (tlo),
    .tfull (tfull),
    .res   (res_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_STAGES; i++) begin
        meta_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      meta_r[0] <= '{valid: issue, index: k_r, last: last};
      for (int i = 1; i < LANE_STAGES; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
      out_valid_r <= meta_tail.valid;
    end
  end

  assign meta_tail = meta_r[LANE_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r <= $signed(res_x);
      out_y_r <= $signed(res_y);
      out_idx_r <= meta_tail.index;
      out_last_r <= meta_tail.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_curve_x = out_x_r;
  assign out_curve_y = out_y_r;
  assign out_sample_index = out_idx_r;
  assign out_last = out_last_r;

`ifndef SYNTHESIS
  a_t_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    t_r <= T_ONE)
    else $error("parameter accumulator above one");

  a_t_starts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r == '0) |-> (t_r == '0))
    else $error("segment run does not start at t zero");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !qstat.empty)
    else $error("window queue popped while empty");

  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_ready))
    else $error("result dropped before transfer");
`endif

endmodule

/* rtl/cubic_bspline_segment_eval_unit.sv */
// Channel  Handshake                 Payload
// in       in_valid / in_ready       in_action, in_ctrl_x, in_ctrl_y
// out      out_valid / out_ready     out_curve_x, out_curve_y, out_sample_index, out_last
// cfg      cfg_we (no wait)          cfg_index, cfg_wdata
//
// A push that completes a four-point window queues the window; the evaluator then
// issues n+1 samples, n being segment_count with zero as one, one per cycle when not stalled.
// Each sample passes through the Horner multiply lanes, then sits in the output register.
// Clears and window-filling pushes queue nothing; input stalls only on a full queue.
// Reset is synchronous, active low, and restores segment_count 16 and step_fraction 4096.
module cubic_bspline_segment_eval_unit #(
  parameter int COORD_WIDTH = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic signed [COORD_WIDTH-1:0]      in_ctrl_x,
  input  logic signed [COORD_WIDTH-1:0]      in_ctrl_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [COORD_WIDTH+7:0]      out_curve_x,
  output logic signed [COORD_WIDTH+7:0]      out_curve_y,
  output logic [cbs_pkg::SEG_W-1:0]          out_sample_index,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [cbs_pkg::STEP_W-1:0]         cfg_wdata
);
  import cbs_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic [SEG_W-1:0]  seg_r, seg_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  cbs_qstat_t        qstat;
  logic              q_push;
  logic              q_pop;
  logic [8*CW-1:0]   q_wdata;
  logic [8*CW-1:0]   q_head;

  always_comb begin
    seg_nxt = seg_r;
    step_nxt = step_r;
    if (cfg_we) begin
      case (cbs_cfg_idx_t'(cfg_index))
        CFG_SEGMENT_COUNT: seg_nxt = cfg_wdata[SEG_W-1:0];
        CFG_STEP_FRACTION: step_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SEG_W'(16);
      step_r <= STEP_W'(4096);
    end else begin
      seg_r <= seg_nxt;
      step_r <= step_nxt;
    end
  end

  cbs_front #(.CW(CW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_ctrl_x (in_ctrl_x),
    .in_ctrl_y (in_ctrl_y),
    .qstat     (qstat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  cbs_queue #(.WIDTH(8*CW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .qstat (qstat)
  );

  cbs_back #(.CW(CW)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .seg_count        (seg_r),
    .step             (step_r),
    .q_head           (q_head),
    .qstat            (qstat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_curve_x      (out_curve_x),
    .out_curve_y      (out_curve_y),
    .out_sample_index (out_sample_index),
    .out_last         (out_last)
  );

endmodule

/* tb/sv/tb_cubic_bspline_segment_eval_unit.sv */
module tb_cubic_bspline_segment_eval_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cbs_pkg::*;

  localparam int COORD_W = 16;
  localparam int CURVE_W = COORD_W + 8;
  localparam longint ONE_Q16 = 65536;
  localparam int DRAIN_CYCLES = 2 * LANE_STAGES + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 30;

  typedef struct {
    logic signed [CURVE_W-1:0] x;
    logic signed [CURVE_W-1:0] y;
    logic [SEG_W-1:0]          idx;
    logic                      last;
  } curve_pt_t;

  typedef enum {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_pattern_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_action;
  logic signed [COORD_W-1:0] in_ctrl_x;
  logic signed [COORD_W-1:0] in_ctrl_y;
  logic out_valid;
  logic out_ready;
  logic signed [CURVE_W-1:0] out_curve_x;
  logic signed [CURVE_W-1:0] out_curve_y;
  logic [SEG_W-1:0] out_sample_index;
  logic out_last;
  logic cfg_we;
  logic cfg_index;
  logic [STEP_W-1:0] cfg_wdata;

  // Predictor state: segment window and register copies.
  longint win_x [4];
  longint win_y [4];
  int pts_held;
  logic [SEG_W-1:0] seg_cfg;
  logic [STEP_W-1:0] step_cfg;

  curve_pt_t curve_queue [$];
  curve_pt_t want;
  int fail_count = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int rx_left = 0;
  int rx_tick = 0;
  rx_pattern_t rx_mode = RX_STEADY;

  always #6 clk = ~clk;

  cubic_bspline_segment_eval_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_ctrl_x        (in_ctrl_x),
    .in_ctrl_y        (in_ctrl_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_curve_x      (out_curve_x),
    .out_curve_y      (out_curve_y),
    .out_sample_index (out_sample_index),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // One coordinate of the segment at parameter t (Q1.16), rounded to Q15.8.
  // The weighted sum needs more than 64 bits, so it is formed at 96 bits.
  function automatic logic signed [CURVE_W-1:0] eval_axis(input longint p0, p1, p2, p3,
                                                          input longint t);
    longint s;
    longint u;
    longint t2;
    longint t3;
    longint s3;
    longint w [4];
    longint pv [4];
    logic signed [95:0] acc;
    logic signed [95:0] wide_p;
    logic signed [95:0] wide_w;
    longint q;
    longint num;
    longint den;
    longint r;
    s = ONE_Q16;
    u = s - t;
    t2 = t * t;
    t3 = t2 * t;
    s3 = s * s * s;
    w[0] = u * u * u;
    w[1] = 3 * t3 - 6 * t2 * s + 4 * s3;
    w[2] = -3 * t3 + 3 * t2 * s + 3 * t * s * s + s3;
    w[3] = t3;
    pv[0] = p0;
    pv[1] = p1;
    pv[2] = p2;
    pv[3] = p3;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      wide_p = pv[i];
      wide_w = w[i];
      acc = acc + wide_p * wide_w;
    end
    // Arithmetic shift floors; the sum is then scaled by 6 * 2^16 with half rounded up.
    q = longint'(acc >>> 24);
    num = q + 3 * 65536;
    den = 6 * 65536;
    if (num >= 0) begin
      r = num / den;
    end else begin
      r = -((-num + den - 1) / den);
    end
    return r[CURVE_W-1:0];
  endfunction

  function automatic void predict_item(input cbs_action_t act,
                                       input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y);
    int n_eff;
    longint t;
    curve_pt_t pt;
    if (act == ACT_CLEAR) begin
      for (int i = 0; i < 4; i++) begin
        win_x[i] = 0;
        win_y[i] = 0;
      end
      pts_held = 0;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      win_x[i] = win_x[i+1];
      win_y[i] = win_y[i+1];
    end
    win_x[3] = x;
    win_y[3] = y;
    if (pts_held < WIN_PTS) pts_held++;
    if (pts_held < WIN_PTS) return;
    n_eff = (seg_cfg == 0) ? 1 : int'(seg_cfg);
    if (n_eff > MAX_SEGMENTS) n_eff = MAX_SEGMENTS;
    for (int k = 0; k <= n_eff; k++) begin
      t = longint'(k) * longint'(step_cfg);
      if (t > ONE_Q16 || k == n_eff) t = ONE_Q16;
      pt.x = eval_axis(win_x[0], win_x[1], win_x[2], win_x[3], t);
      pt.y = eval_axis(win_y[0], win_y[1], win_y[2], win_y[3], t);
      pt.idx = SEG_W'(k);
      pt.last = (k == n_eff);
      curve_queue.insert(curve_queue.size(), pt);
    end
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // The sender works in bursts; valid stays high across a burst.
  task automatic send_item(input cbs_action_t act,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_ctrl_x <= x;
    in_ctrl_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(act, x, y);
  endtask

  task automatic send_random_item();
    cbs_action_t act;
    act = ($urandom_range(0, 11) == 0) ? ACT_CLEAR : ACT_PUSH;
    send_item(act, rand_coord(), rand_coord());
  endtask

  // Lets every expected result out, then covers items that produce none.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (curve_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [STEP_W-1:0] seg_word,
                           input logic [STEP_W-1:0] step_word);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SEGMENT_COUNT;
    cfg_wdata <= seg_word;
    @(posedge clk);
    cfg_index <= CFG_STEP_FRACTION;
    cfg_wdata <= step_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    seg_cfg = seg_word[SEG_W-1:0];
    step_cfg = step_word;
    @(posedge clk);
  endtask

  // Reset values of the registers; the first three pushes only fill the window.
  task automatic test_window_fill();
    send_item(ACT_PUSH, 16'sh8000, 16'sh7FFF);
    send_item(ACT_PUSH, 16'sh7FFF, 16'sh8000);
    send_item(ACT_PUSH, 16'sh0000, 16'sh0000);
    send_item(ACT_PUSH, -16'sd1, 16'sd1);
    send_item(ACT_PUSH, 16'sh7FFF, 16'sh7FFF);
  endtask

  task automatic test_clear_window();
    send_item(ACT_CLEAR, rand_coord(), rand_coord());
    send_item(ACT_PUSH, 16'sd100, -16'sd100);
    send_item(ACT_PUSH, 16'sh8000, 16'sh8000);
    send_item(ACT_CLEAR, 16'sh7FFF, 16'sh8000);
    send_item(ACT_PUSH, 16'sh7FFF, 16'sh8000);
    send_item(ACT_PUSH, 16'sh8000, 16'sh7FFF);
    send_item(ACT_PUSH, 16'sh7FFF, 16'sh8000);
    send_item(ACT_PUSH, 16'sh8000, 16'sh7FFF);
  endtask

  task automatic test_config_extremes();
    // Zero segment count acts as one; the upper data bits must be ignored.
    wait_drained();
    write_cfg(17'h1FFC0, 17'h00000);
    send_item(ACT_PUSH, 16'sd12345, -16'sd23456);
    send_item(ACT_PUSH, 16'sh8000, 16'sh7FFF);
    // Step above one saturates from the second sample on.
    wait_drained();
    write_cfg(17'd63, 17'h1FFFF);
    send_item(ACT_PUSH, 16'sh7FFF, 16'sh8000);
    wait_drained();
    write_cfg(17'd63, 17'd1040);
    send_item(ACT_PUSH, -16'sd7, 16'sd9);
    wait_drained();
    write_cfg(17'd1, 17'd65536);
    send_item(ACT_PUSH, 16'sd1, -16'sd1);
    wait_drained();
    write_cfg(17'd5, 17'd1);
    send_item(ACT_PUSH, 16'sh8000, 16'sh8000);
  endtask

  task automatic test_random_streams();
    int n_pick;
    logic [STEP_W-1:0] seg_word;
    logic [STEP_W-1:0] step_word;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: n_pick = $urandom_range(1, 8);
        6, 7: n_pick = $urandom_range(9, 24);
        8: n_pick = 63;
        default: n_pick = 0;
      endcase
      seg_word = {11'($urandom), 6'(n_pick)};
      if (n_pick == 0) n_pick = 1;
      case ($urandom_range(0, 7))
        0, 1, 2, 3: step_word = 17'(65536 / n_pick);
        4: step_word = 17'($urandom);
        5: step_word = '0;
        6: step_word = ($urandom_range(0, 1) == 1) ? 17'd65536 : 17'h1FFFF;
        default: step_word = 17'($urandom_range(1, 65536 / n_pick));
      endcase
      wait_drained();
      write_cfg(seg_word, step_word);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_item();
    end
  endtask

  // Receiver back-pressure: a randomly chosen pattern, held for a random span, then replaced.
  always @(posedge clk) begin
    if (rst_n) begin
      rx_tick <= rx_tick + 1;
      if (rx_left == 0) begin
        rx_mode <= rx_pattern_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(20, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_COIN: out_ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((rx_tick % 5) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (curve_queue.size() == 0) begin
        $error("unexpected curve point transfer: index %0d", out_sample_index);
        fail_count++;
      end else begin
        want = curve_queue.pop_front();
        if (out_curve_x !== want.x) begin
          $error("curve_x mismatch: expected %0d, got %0d", want.x, out_curve_x);
          fail_count++;
        end
        if (out_curve_y !== want.y) begin
          $error("curve_y mismatch: expected %0d, got %0d", want.y, out_curve_y);
          fail_count++;
        end
        if (out_sample_index !== want.idx) begin
          $error("sample_index mismatch: expected %0d, got %0d", want.idx, out_sample_index);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last mismatch: expected %0d, got %0d", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL cubic_bspline_segment_eval_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_PUSH;
    in_ctrl_x <= '0;
    in_ctrl_y <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SEGMENT_COUNT;
    cfg_wdata <= '0;
    seg_cfg = 6'd16;
    step_cfg = 17'd4096;
    pts_held = 0;
    for (int i = 0; i < 4; i++) begin
      win_x[i] = 0;
      win_y[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_window_fill();
    test_clear_window();
    test_config_extremes();
    test_random_streams();
    wait_drained();
    if (fail_count == 0) begin
      $display("PASS cubic_bspline_segment_eval_unit");
    end else begin
      $display("FAIL cubic_bspline_segment_eval_unit");
    end
    $finish;
  end

endmodule
